>>> rtl/core/pkfc_pkg.sv
package pkfc_pkg;

   localparam int unsigned MAX_DATA_BYTES         = 524288;
   localparam int unsigned PRIMARY_HEADER_BYTES   = 24;
   localparam int unsigned SECONDARY_HEADER_BYTES = 12;

   localparam int unsigned CNT_W      = 24;
   localparam int unsigned LEN_W      = 20;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // one bit wider than the counter so that a limit of 2**CNT_W still compares
   localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(MAX_DATA_BYTES);

   typedef enum logic [1:0] {
      CSUM_NONE = 2'd0,
      CSUM_8    = 2'd1,
      CSUM_16   = 2'd2,
      CSUM_32   = 2'd3
   } csum_mode_type;

   typedef enum logic {
      REG_CSUM_MODE = 1'b0,
      REG_SEC_HDR   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             out_last;
      logic [LEN_W-1:0] packet_length;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      csum_mode_type checksum_mode;
      logic          secondary_header_on;
   } cfg_type;

   // everything the emitter needs to send the words caused by one item
   typedef struct packed {
      logic             data_vld;
      logic [7:0]       data_byte;
      logic             data_last;
      logic [2:0]       tcnt;
      logic [1:0]       pad;
      logic [31:0]      sum;
      logic [LEN_W-1:0] len;
      logic             ovf;
   } desc_type;

endpackage

>>> rtl/core/pkfc_csr.sv
module pkfc_csr import pkfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_CSUM_MODE: cfg_in.checksum_mode       = csum_mode_type'(csr_pwdata[1:0]);
            REG_SEC_HDR:   cfg_in.secondary_header_on = csr_pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{checksum_mode: CSUM_NONE, secondary_header_on: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_CSUM_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.checksum_mode);
         REG_SEC_HDR:   csr_prdata = CSR_DATA_W'(cfg_ff.secondary_header_on);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/core/pkfc_accum.sv
module pkfc_accum import pkfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     desc_take,
   output logic     desc_vld,
   output desc_type desc
);

   logic [31:0]      sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             desc_vld_ff, desc_vld_in;
   desc_type         desc_ff, desc_in;

   logic             req_fire;
   logic             full;
   logic             take_byte;
   logic             dropped;
   logic [31:0]      addend;
   logic [31:0]      sum_next;
   logic [CNT_W-1:0] count_next;
   logic             ovf_next;
   logic [2:0]       csize;
   logic [1:0]       pad;
   logic [2:0]       trail;
   logic [LEN_W-1:0] padded;
   logic [LEN_W-1:0] len;
   logic [31:0]      sum_masked;
   logic [2:0]       tcnt;

   assign req_ready = !desc_vld_ff || desc_take;
   assign req_fire  = req_valid && req_ready;

   assign full      = {1'b0, count_ff} >= CNT_LIMIT;
   assign take_byte = req_data.has_byte && !full;
   assign dropped   = req_data.has_byte && full;

   // byte lands in the lane given by its position within the halfword or word
   always_comb begin
      unique case (cfg.checksum_mode)
         CSUM_NONE: addend = '0;
         CSUM_8:    addend = 32'(req_data.data_byte);
         CSUM_16:   addend = 32'(req_data.data_byte) << {count_ff[0], 3'b000};
         CSUM_32:   addend = 32'(req_data.data_byte) << {count_ff[1:0], 3'b000};
         default:   addend = '0;
      endcase
   end

   assign sum_next   = sum_ff + (take_byte ? addend : 32'd0);
   assign count_next = count_ff + CNT_W'(take_byte);
   assign ovf_next   = ovf_ff | dropped;

   always_comb begin
      unique case (cfg.checksum_mode)
         CSUM_NONE: begin
            csize      = 3'd0;
            sum_masked = '0;
         end
         CSUM_8: begin
            csize      = 3'd1;
            sum_masked = {24'd0, sum_next[7:0]};
         end
         CSUM_16: begin
            csize      = 3'd2;
            sum_masked = {16'd0, sum_next[15:0]};
         end
         CSUM_32: begin
            csize      = 3'd4;
            sum_masked = sum_next;
         end
         default: begin
            csize      = 3'd0;
            sum_masked = '0;
         end
      endcase
   end

   // zero filler up to the next word boundary once the checksum is counted in
   assign pad    = 2'(2'b00 - (count_next[1:0] + csize[1:0]));
   assign trail  = csize + {1'b0, pad};
   assign padded = count_next[LEN_W-1:0] + LEN_W'(trail);
   assign len    = padded + LEN_W'(PRIMARY_HEADER_BYTES)
                 + (cfg.secondary_header_on ? LEN_W'(SECONDARY_HEADER_BYTES) : LEN_W'(0));

   // with no trailer and no data byte a lone marker word carries the end
   always_comb begin
      if (!req_data.end_of_data) begin
         tcnt = 3'd0;
      end else if (trail != 3'd0) begin
         tcnt = trail;
      end else begin
         tcnt = take_byte ? 3'd0 : 3'd1;
      end
   end

   always_comb begin
      desc_in.data_vld  = take_byte;
      desc_in.data_byte = req_data.data_byte;
      desc_in.data_last = req_data.end_of_data && (trail == 3'd0);
      desc_in.tcnt      = tcnt;
      desc_in.pad       = pad;
      desc_in.sum       = sum_masked;
      desc_in.len       = len;
      desc_in.ovf       = ovf_next;
   end

   always_comb begin
      sum_in      = sum_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      desc_vld_in = desc_vld_ff;
      if (req_fire) begin
         desc_vld_in = take_byte || req_data.end_of_data;
         if (req_data.end_of_data) begin
            sum_in   = '0;
            count_in = '0;
            ovf_in   = 1'b0;
         end else begin
            sum_in   = sum_next;
            count_in = count_next;
            ovf_in   = ovf_next;
         end
      end else if (desc_take) begin
         desc_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         desc_vld_ff <= 1'b0;
      end else begin
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         desc_vld_ff <= desc_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         desc_ff <= desc_in;
      end
   end

   assign desc_vld = desc_vld_ff;
   assign desc     = desc_ff;

endmodule

>>> rtl/core/pkfc_emit.sv
module pkfc_emit import pkfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     desc_vld,
   input  desc_type desc,
   output logic     desc_take,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic [2:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       is_data;
   logic [2:0] idx;
   logic [1:0] sel;
   logic       in_csum;
   logic [7:0] tail_byte;
   logic       tail_last;
   logic       item_final;
   logic       out_load;

   assign is_data   = desc.data_vld && (pos_ff == 3'd0);
   assign idx       = pos_ff - {2'b00, desc.data_vld};
   assign sel       = 2'(idx - {1'b0, desc.pad});
   assign in_csum   = idx >= {1'b0, desc.pad};
   assign tail_byte = in_csum ? 8'(desc.sum >> {sel, 3'b000}) : 8'd0;
   assign tail_last = (idx + 3'd1) == desc.tcnt;

   assign item_final = is_data ? (desc.tcnt == 3'd0) : tail_last;
   assign out_load   = desc_vld && (!rsp_valid_ff || rsp_ready);
   assign desc_take  = out_load && item_final;

   always_comb begin
      if (is_data) begin
         rsp_data_in.out_byte      = desc.data_byte;
         rsp_data_in.out_last      = desc.data_last;
         rsp_data_in.packet_length = desc.data_last ? desc.len : '0;
      end else begin
         rsp_data_in.out_byte      = tail_byte;
         rsp_data_in.out_last      = tail_last;
         rsp_data_in.packet_length = tail_last ? desc.len : '0;
      end
      rsp_data_in.overflow = desc.ovf;
   end

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         pos_in       = item_final ? 3'd0 : pos_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/packet_filler_and_checksum_unit.sv
// An accepted item is registered in the descriptor stage, then its first word in
// the output register. Throughput, while rsp_ready holds: one item per cycle while
// each item yields one word; an end item sends one byte per cycle through the
// single output register, and new items wait behind it in a one-entry stage.
// Reset: configuration, sum, count and overflow clear; no word is pending.
module packet_filler_and_checksum_unit import pkfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   logic     desc_vld;
   logic     desc_take;
   desc_type desc;

   pkfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pkfc_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .desc_take (desc_take),
      .desc_vld  (desc_vld),
      .desc      (desc)
   );

   pkfc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .desc_vld  (desc_vld),
      .desc      (desc),
      .desc_take (desc_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // length is only reported on the closing word of a buffer
   a_len_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |-> rsp_data.packet_length == '0)
      else $error("packet length on a word that is not last");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("word pending straight after reset");

   // a stalled output must not lose its pending word to a new load
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pending word dropped while stalled");

endmodule
